>>> rtl/tabular_q_learning_engine_macros.svh
// assertion macros for the q-learning engine rtl
`ifndef TABULAR_Q_LEARNING_ENGINE_MACROS_SVH
`define TABULAR_Q_LEARNING_ENGINE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define QLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define QLE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qle_pkg.sv
// shared types and constants of the q-learning engine
`timescale 1ns / 1ps
package qle_pkg;

  localparam int NUM_ACTIONS = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [16:0] ONE_Q1_16 = 17'd65536;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // reset values of the configuration registers
  localparam logic [16:0] ALPHA_RST = 17'd6554;
  localparam logic [16:0] GAMMA_RST = 17'd58982;
  localparam logic [16:0] EPS_RST   = 17'd6554;
  localparam logic [16:0] DECAY_RST = 17'd65209;
  localparam logic [16:0] MIN_RST   = 17'd655;

  typedef enum logic [1:0] {
    MODE_CHOOSE = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_DECAY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_ALPHA = 3'd0,
    CFG_GAMMA = 3'd1,
    CFG_EPS   = 3'd2,
    CFG_DECAY = 3'd3,
    CFG_MIN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_TGT,
    ST_MUL2,
    ST_UPD,
    ST_DECAY,
    ST_DONE
  } state_e;

  // configuration seen by the back end
  typedef struct packed {
    logic [16:0] alpha;
    logic [16:0] gamma;
    logic [16:0] init_eps;
    logic [16:0] decay;
    logic [16:0] min_eps;
  } cfg_t;

  // decoded request passed from front to back
  typedef struct packed {
    mode_e              mode;
    logic [2:0]         pos_x;
    logic [2:0]         pos_y;
    logic [1:0]         act;
    logic signed [31:0] reward;
    logic [2:0]         next_x;
    logic [2:0]         next_y;
    logic [15:0]        frac;
    logic [1:0]         rand_act;
    logic               pos_off;
    logic               next_off;
  } cmd_t;

  // back end control toward the front
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

>>> rtl/qle_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface qle_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         pos_x;
  logic [2:0]         pos_y;
  logic [1:0]         taken_action;
  logic signed [31:0] reward;
  logic [2:0]         next_x;
  logic [2:0]         next_y;
  logic [15:0]        rand_frac;
  logic [1:0]         rand_action;

  modport source (output valid, mode, pos_x, pos_y, taken_action, reward, next_x, next_y,
                  rand_frac, rand_action, input ready);
  modport sink (input valid, mode, pos_x, pos_y, taken_action, reward, next_x, next_y,
                rand_frac, rand_action, output ready);
endinterface

interface qle_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         chosen_action;
  logic               explored;
  logic signed [31:0] q_value;
  logic [16:0]        exploration_now;

  modport source (output valid, chosen_action, explored, q_value, exploration_now,
                  input ready);
  modport sink (input valid, chosen_action, explored, q_value, exploration_now,
                output ready);
endinterface

>>> rtl/qle_front.sv
// request intake: decode, grid check and a short command queue
`timescale 1ns / 1ps
module qle_front import qle_pkg::*; #(
  parameter int GRID_DIM = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qle_req_if.sink   req_i,
  input  back_ctl_t ctl_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            fifo_q [QUEUE_DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_new;

  // accept while there is room and the table is not being cleared
  assign req_i.ready = (cnt_q != (PW+1)'(QUEUE_DEPTH)) && !ctl_i.clearing;
  assign push        = req_i.valid && req_i.ready;

  // classify the request
  always_comb begin
    cmd_new.mode     = mode_e'(req_i.mode);
    cmd_new.pos_x    = req_i.pos_x;
    cmd_new.pos_y    = req_i.pos_y;
    cmd_new.act      = req_i.taken_action;
    cmd_new.reward   = req_i.reward;
    cmd_new.next_x   = req_i.next_x;
    cmd_new.next_y   = req_i.next_y;
    cmd_new.frac     = req_i.rand_frac;
    cmd_new.rand_act = req_i.rand_action;
    cmd_new.pos_off  = (32'(req_i.pos_x) >= GRID_DIM) || (32'(req_i.pos_y) >= GRID_DIM);
    cmd_new.next_off = (32'(req_i.next_x) >= GRID_DIM) || (32'(req_i.next_y) >= GRID_DIM);
  end

  // queue pointers
  always_comb begin
    wp_d  = push ? wp_q + 1'b1 : wp_q;
    rp_d  = ctl_i.pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rp_q];

endmodule

>>> rtl/qle_back.sv
// execution: q table memory, sequencer, fixed point arithmetic, result register
`timescale 1ns / 1ps
`include "tabular_q_learning_engine_macros.svh"
module qle_back import qle_pkg::*; #(
  parameter int GRID_DIM = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      eps_wr_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output back_ctl_t ctl_o,
  qle_rsp_if.source rsp_o
);

  localparam int DEPTH = GRID_DIM * GRID_DIM * NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [16:0]        eps_q, eps_d;
  logic signed [31:0] best_q, best_d, cur_q, cur_d, qv_q, qv_d;
  logic [1:0]         pick_q, pick_d;
  logic signed [49:0] p1_q, p1_d;
  logic signed [34:0] tgt_q, tgt_d;
  logic signed [52:0] p2_q, p2_d;
  logic               out_vld_q, out_vld_d;
  logic [1:0]         out_act_q, out_act_d;
  logic               out_exp_q, out_exp_d;
  logic signed [31:0] out_qv_q, out_qv_d;
  logic [16:0]        out_eps_q, out_eps_d;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata;

  logic [2:0]         n_reads, j;
  logic               use_pos, off_j, explore;
  logic [2:0]         rx, ry;
  logic [1:0]         ra;
  logic signed [31:0] v;
  logic signed [37:0] nq;
  logic [33:0]        eprod;
  logic [17:0]        enew;

  function automatic logic [AW-1:0] addr_of(logic [2:0] x, logic [2:0] y, logic [1:0] a);
    return AW'((32'(y) * GRID_DIM + 32'(x)) * NUM_ACTIONS + 32'(a));
  endfunction

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // read sequencing helpers
  always_comb begin
    n_reads = (cmd_q.mode == MODE_CHOOSE) ? 3'd4 : 3'd5;
    j       = cnt_q - 3'd1;
    use_pos = (cmd_q.mode == MODE_CHOOSE) || (cnt_q == 3'd4);
    rx      = use_pos ? cmd_q.pos_x : cmd_q.next_x;
    ry      = use_pos ? cmd_q.pos_y : cmd_q.next_y;
    ra      = (cnt_q == 3'd4) ? cmd_q.act : cnt_q[1:0];
    off_j   = ((cmd_q.mode == MODE_CHOOSE) || (j == 3'd4)) ? cmd_q.pos_off : cmd_q.next_off;
    v       = off_j ? Q_ONE : rdata_q;
    explore = ({1'b0, cmd_q.frac} < eps_q);
    nq      = 38'(cur_q) + 38'(p2_q >>> 16);
    eprod   = 34'(eps_q) * 34'(cfg_i.decay);
    enew    = eprod[33:16];
    if (enew < {1'b0, cfg_i.min_eps}) begin
      enew = {1'b0, cfg_i.min_eps};
    end
    if (enew > {1'b0, ONE_Q1_16}) begin
      enew = {1'b0, ONE_Q1_16};
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    clr_cnt_d = clr_cnt_q;
    cnt_d     = cnt_q;
    eps_d     = eps_wr_i ? cfg_i.init_eps : eps_q;
    best_d    = best_q;
    pick_d    = pick_q;
    cur_d     = cur_q;
    qv_d      = qv_q;
    p1_d      = p1_q;
    tgt_d     = tgt_q;
    p2_d      = p2_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_act_d = out_act_q;
    out_exp_d = out_exp_q;
    out_qv_d  = out_qv_q;
    out_eps_d = out_eps_q;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = Q_ONE;
    mem_raddr = addr_of(rx, ry, ra);
    ctl_o.pop      = 1'b0;
    ctl_o.clearing = (state_q == ST_CLEAR);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          ctl_o.pop = 1'b1;
          cmd_d     = cmd_i;
          cnt_d     = '0;
          qv_d      = '0;
          case (cmd_i.mode) inside
            MODE_CHOOSE, MODE_UPDATE: state_d = ST_READ;
            MODE_DECAY:               state_d = ST_DECAY;
            default:                  state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 3'd1;
        // fold in the entry requested in the previous cycle
        if (cnt_q != 3'd0) begin
          if (j == 3'd4) begin
            cur_d = v;
          end else if (j == 3'd0 || v > best_q) begin
            best_d = v;
            pick_d = j[1:0];
          end
        end
        if (cnt_q == n_reads) begin
          if (cmd_q.mode == MODE_CHOOSE) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        p1_d    = $signed({1'b0, cfg_i.gamma}) * best_q;
        state_d = ST_TGT;
      end
      ST_TGT: begin
        tgt_d   = 35'(cmd_q.reward) + 35'(p1_q >>> 16) - 35'(cur_q);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        p2_d    = $signed({1'b0, cfg_i.alpha}) * tgt_q;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // saturate to 32 bits and store unless the position is off the grid
        if (nq > 38'(Q_MAX)) begin
          qv_d = Q_MAX;
        end else if (nq < 38'(Q_MIN)) begin
          qv_d = Q_MIN;
        end else begin
          qv_d = 32'(nq);
        end
        mem_we    = !cmd_q.pos_off;
        mem_waddr = addr_of(cmd_q.pos_x, cmd_q.pos_y, cmd_q.act);
        mem_wdata = qv_d;
        state_d   = ST_DONE;
      end
      ST_DECAY: begin
        eps_d   = enew[16:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_eps_d = eps_q;
          out_act_d = '0;
          out_exp_d = 1'b0;
          out_qv_d  = qv_q;
          if (cmd_q.mode == MODE_CHOOSE) begin
            out_exp_d = explore;
            out_act_d = explore ? cmd_q.rand_act : pick_q;
            out_qv_d  = best_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      eps_q     <= EPS_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      eps_q     <= eps_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cnt_q     <= cnt_d;
    best_q    <= best_d;
    pick_q    <= pick_d;
    cur_q     <= cur_d;
    qv_q      <= qv_d;
    p1_q      <= p1_d;
    tgt_q     <= tgt_d;
    p2_q      <= p2_d;
    out_act_q <= out_act_d;
    out_exp_q <= out_exp_d;
    out_qv_q  <= out_qv_d;
    out_eps_q <= out_eps_d;
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.chosen_action   = out_act_q;
  assign rsp_o.explored        = out_exp_q;
  assign rsp_o.q_value         = out_qv_q;
  assign rsp_o.exploration_now = out_eps_q;

  // checks
  `QLE_ASSERT(a_no_write_idle, !(state_q == ST_IDLE && mem_we), "table written while idle")
  `QLE_ASSERT(a_pop_idle, !ctl_o.pop || state_q == ST_IDLE, "queue popped outside idle")
  `QLE_ASSERT(a_eps_le_one, eps_q <= ONE_Q1_16, "epsilon above one")
  `QLE_ASSERT_NEXT(a_clear_end, state_q == ST_CLEAR && clr_cnt_q == AW'(DEPTH - 1), state_q == ST_IDLE, "clearing pass did not finish")

endmodule

>>> rtl/tabular_q_learning_engine.sv
// Tabular Q-learning engine, top level with configuration registers.
// After reset a clearing pass sets all GRID_DIM*GRID_DIM*4 Q table entries (256 at
// the default grid) to 1.0; no request is taken until it ends. Each request is then
// run alone through one table memory, one entry read per cycle: choose reads the
// four entries of its position, update reads five and then runs two dependent
// registered multiplies, decay steps epsilon and the no-op mode only returns a
// result. A two-entry command queue in front and a result register behind let
// requests arrive and results wait without stalling the other side.
`timescale 1ns / 1ps
module tabular_q_learning_engine import qle_pkg::*; #(
  parameter int GRID_DIM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qle_req_if.sink     req_i,
  qle_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  cfg_t        cfg_q, cfg_d;
  logic        eps_wr;
  logic [16:0] wval;
  logic        cmd_valid;
  cmd_t        cmd;
  back_ctl_t   ctl;

  // register writes, saturated to one
  always_comb begin
    cfg_d  = cfg_q;
    eps_wr = 1'b0;
    wval   = (cfg_wdata_i > ONE_Q1_16) ? ONE_Q1_16 : cfg_wdata_i;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA: cfg_d.alpha = wval;
        CFG_GAMMA: cfg_d.gamma = wval;
        CFG_EPS: begin
          cfg_d.init_eps = wval;
          eps_wr         = 1'b1;
        end
        CFG_DECAY: cfg_d.decay   = wval;
        CFG_MIN:   cfg_d.min_eps = wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha    <= ALPHA_RST;
      cfg_q.gamma    <= GAMMA_RST;
      cfg_q.init_eps <= EPS_RST;
      cfg_q.decay    <= DECAY_RST;
      cfg_q.min_eps  <= MIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request intake
  qle_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // execution
  qle_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_d),
    .eps_wr_i    (eps_wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .ctl_o       (ctl),
    .rsp_o       (rsp_o)
  );

endmodule

>>> bench/tabular_q_learning_engine_tb.sv
// self-checking bench for the tabular q-learning engine
`timescale 1ns / 1ps
module tabular_q_learning_engine_tb;
  import qle_pkg::*;

  localparam int GRID = 8;
  localparam int DEPTH = GRID * GRID * NUM_ACTIONS;
  localparam int RANDOM_ITEMS = 950;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         pos_x;
    logic [2:0]         pos_y;
    logic [1:0]         act;
    logic signed [31:0] reward;
    logic [2:0]         next_x;
    logic [2:0]         next_y;
    logic [15:0]        frac;
    logic [1:0]         rand_act;
  } request_t;

  typedef struct packed {
    logic [1:0]         chosen;
    logic               explored;
    logic signed [31:0] q_value;
    logic [16:0]        eps;
  } outcome_t;

  // directed row: request plus optional typed-in result
  typedef struct packed {
    request_t req;
    logic     has_known;
    outcome_t known;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [16:0] cfg_wdata_i;

  qle_req_if req_if ();
  qle_rsp_if rsp_if ();

  tabular_q_learning_engine #(.GRID_DIM(GRID)) dut (
    .clk_i, .rst_ni, .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // shadow state of the engine
  logic signed [31:0] q_shadow [DEPTH];
  logic [16:0] alpha_s, gamma_s, decay_s, min_s, eps_s;

  outcome_t expected_q[$];
  int mismatches;
  int idle_cycles;
  bit rsp_hold;
  bit quiet_phase;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] floor16(logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic signed [31:0] table_q(logic [2:0] x, logic [2:0] y, logic [1:0] a);
    return q_shadow[(int'(y) * GRID + int'(x)) * NUM_ACTIONS + int'(a)];
  endfunction

  // best action of a position, lowest index on ties
  function automatic logic [1:0] best_of(logic [2:0] x, logic [2:0] y,
                                         output logic signed [31:0] top);
    logic [1:0] pick;
    pick = 2'd0;
    top = table_q(x, y, 2'd0);
    for (int a = 1; a < NUM_ACTIONS; a++) begin
      if (table_q(x, y, a[1:0]) > top) begin
        top = table_q(x, y, a[1:0]);
        pick = a[1:0];
      end
    end
    return pick;
  endfunction

  function automatic outcome_t predict_step(request_t r);
    outcome_t o;
    logic signed [31:0] best, nbest, cur;
    logic signed [63:0] tgt, nq;
    logic [1:0] pick;
    logic [33:0] e;
    o = '0;
    case (mode_e'(r.mode))
      MODE_CHOOSE: begin
        pick = best_of(r.pos_x, r.pos_y, best);
        if (r.frac < eps_s) begin
          o.chosen = r.rand_act;
          o.explored = 1'b1;
        end else begin
          o.chosen = pick;
        end
        o.q_value = best;
      end
      MODE_UPDATE: begin
        cur = table_q(r.pos_x, r.pos_y, r.act);
        pick = best_of(r.next_x, r.next_y, nbest);
        tgt = 64'(r.reward) + floor16($signed({47'd0, gamma_s}) * 64'(nbest)) - 64'(cur);
        nq = 64'(cur) + floor16($signed({47'd0, alpha_s}) * tgt);
        if (nq > 64'(Q_MAX)) nq = 64'(Q_MAX);
        if (nq < 64'(Q_MIN)) nq = 64'(Q_MIN);
        q_shadow[(int'(r.pos_y) * GRID + int'(r.pos_x)) * NUM_ACTIONS + int'(r.act)] = nq[31:0];
        o.q_value = nq[31:0];
      end
      MODE_DECAY: begin
        e = (34'(eps_s) * 34'(decay_s)) >> 16;
        if (e < 34'(min_s)) e = 34'(min_s);
        eps_s = (e > 34'(ONE_Q1_16)) ? ONE_Q1_16 : e[16:0];
      end
      default: ;
    endcase
    o.eps = eps_s;
    return o;
  endfunction

  task automatic reset_shadow();
    foreach (q_shadow[i]) q_shadow[i] = Q_ONE;
    alpha_s = ALPHA_RST;
    gamma_s = GAMMA_RST;
    decay_s = DECAY_RST;
    min_s = MIN_RST;
    eps_s = EPS_RST;
  endtask

  // register write; only while the engine is idle
  task automatic write_reg(cfg_idx_e idx, logic [16:0] val);
    logic [16:0] v;
    v = (val > ONE_Q1_16) ? ONE_Q1_16 : val;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ALPHA: alpha_s = v;
      CFG_GAMMA: gamma_s = v;
      CFG_EPS:   eps_s = v;
      CFG_DECAY: decay_s = v;
      CFG_MIN:   min_s = v;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // send one request, holding valid until accepted
  task automatic send_request(request_t r);
    while (!quiet_phase && $urandom_range(99) < 6) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= r.mode;
    req_if.pos_x <= r.pos_x;
    req_if.pos_y <= r.pos_y;
    req_if.taken_action <= r.act;
    req_if.reward <= r.reward;
    req_if.next_x <= r.next_x;
    req_if.next_y <= r.next_y;
    req_if.rand_frac <= r.frac;
    req_if.rand_action <= r.rand_act;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(predict_step(r));
  endtask

  function automatic request_t random_request();
    request_t r;
    r.mode = ($urandom_range(19) == 0) ? MODE_NOP :
             ($urandom_range(9) == 0) ? MODE_DECAY :
             ($urandom_range(1) == 0) ? MODE_CHOOSE : MODE_UPDATE;
    r.pos_x = 3'($urandom_range(7));
    r.pos_y = ($urandom_range(1) == 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
    r.act = 2'($urandom_range(3));
    case ($urandom_range(5))
      0: r.reward = $urandom;
      1: r.reward = ($urandom_range(1) == 0) ? Q_MAX : Q_MIN;
      default: r.reward = $signed(32'($urandom_range(262143))) - 32'sd131072;
    endcase
    r.next_x = 3'($urandom_range(7));
    r.next_y = ($urandom_range(1) == 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
    r.frac = ($urandom_range(1) == 0) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(13000));
    r.rand_act = 2'($urandom_range(3));
    return r;
  endfunction

  function automatic row_t mk(logic [1:0] m, logic [2:0] px, logic [2:0] py, logic [1:0] a,
                              logic signed [31:0] rw, logic [2:0] nx, logic [2:0] ny,
                              logic [15:0] fr, logic [1:0] ra, logic known,
                              logic [1:0] c, logic ex, logic signed [31:0] qv,
                              logic [16:0] ep);
    row_t row;
    row.req = '{m, px, py, a, rw, nx, ny, fr, ra};
    row.has_known = known;
    row.known = '{c, ex, qv, ep};
    return row;
  endfunction

  // response side: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !rsp_hold && (quiet_phase || $urandom_range(99) >= 6);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", rsp_if.q_value);
      end else begin
        outcome_t e;
        e = expected_q.pop_front();
        if (rsp_if.chosen_action !== e.chosen || rsp_if.explored !== e.explored ||
            rsp_if.q_value !== e.q_value || rsp_if.exploration_now !== e.eps) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0b %0d %0d, got %0d %0b %0d %0d",
                     e.chosen, e.explored, e.q_value, e.eps, rsp_if.chosen_action,
                     rsp_if.explored, rsp_if.q_value, rsp_if.exploration_now);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tabular_q_learning_engine_tb NOT OK");
        $finish;
      end
    end
  end

  // long receiver hold-off, counted here while requests keep coming
  initial begin
    rsp_hold = 1'b0;
    wait (rst_ni);
    repeat (6000) @(posedge clk_i);
    rsp_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    rsp_hold = 1'b0;
  end

  initial begin
    row_t rows [$];
    mismatches = 0;
    idle_cycles = 0;
    quiet_phase = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ALPHA;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_NOP;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.taken_action = '0;
    req_if.reward = '0;
    req_if.next_x = '0;
    req_if.next_y = '0;
    req_if.rand_frac = '0;
    req_if.rand_action = '0;
    reset_shadow();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: after reset, extremes, ties, every mode
    rows.push_back(mk(MODE_CHOOSE, 0, 0, 0, 0, 0, 0, 16'hffff, 3, 1, 0, 0, Q_ONE, EPS_RST));
    rows.push_back(mk(MODE_CHOOSE, 7, 7, 0, 0, 0, 0, 16'd0, 2, 1, 2, 1, Q_ONE, EPS_RST));
    rows.push_back(mk(MODE_NOP, 7, 7, 3, Q_MAX, 7, 7, 16'hffff, 3, 1, 0, 0, 0, EPS_RST));
    rows.push_back(mk(MODE_UPDATE, 0, 0, 3, Q_MAX, 7, 7, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_UPDATE, 7, 7, 1, Q_MIN, 0, 0, 16'hffff, 3, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_UPDATE, 3, 5, 2, 32'sd131072, 3, 5, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_CHOOSE, 0, 0, 0, 0, 0, 0, 16'hffff, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_CHOOSE, 7, 7, 0, 0, 0, 0, 16'hffff, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_CHOOSE, 3, 5, 0, 0, 0, 0, 16'd6553, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_CHOOSE, 3, 5, 0, 0, 0, 0, 16'd6554, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(MODE_UPDATE, 0, 0, 3, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) begin
      send_request(rows[i].req);
      // rows with a typed-in result are checked against it
      if (rows[i].has_known) expected_q[expected_q.size() - 1] = rows[i].known;
    end
    req_if.valid <= 1'b0;
    wait_drained();

    // configuration extremes, then decay to the floor
    write_reg(CFG_ALPHA, ONE_Q1_16);
    write_reg(CFG_GAMMA, 17'h1ffff);
    write_reg(CFG_EPS, 17'd0);
    write_reg(CFG_DECAY, 17'd0);
    write_reg(CFG_MIN, 17'd0);
    send_request('{MODE_DECAY, 3'd0, 3'd0, 2'd0, 32'sd0, 3'd0, 3'd0, 16'd0, 2'd0});
    send_request('{MODE_UPDATE, 3'd1, 3'd1, 2'd1, Q_MAX, 3'd1, 3'd1, 16'd0, 2'd0});
    send_request('{MODE_UPDATE, 3'd2, 3'd1, 2'd0, Q_MIN, 3'd2, 3'd1, 16'd0, 2'd0});
    req_if.valid <= 1'b0;
    wait_drained();
    write_reg(CFG_EPS, 17'd0);
    wait_drained();

    // random phases under several settings
    for (int ph = 0; ph < 5; ph++) begin
      quiet_phase = (ph == 2);
      write_reg(CFG_ALPHA, (ph == 4) ? 17'd0 : 17'($urandom_range(65536)));
      write_reg(CFG_GAMMA, (ph == 3) ? ONE_Q1_16 : 17'($urandom_range(65536)));
      write_reg(CFG_EPS, (ph == 1) ? ONE_Q1_16 : 17'($urandom_range(20000)));
      write_reg(CFG_DECAY, (ph == 0) ? ONE_Q1_16 : 17'($urandom_range(40000, 65536)));
      write_reg(CFG_MIN, (ph == 4) ? 17'h1ffff : 17'($urandom_range(3000)));
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) send_request(random_request());
      req_if.valid <= 1'b0;
      wait_drained();
    end
    quiet_phase = 1'b0;

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tabular_q_learning_engine_tb OK");
    end else begin
      $display("tabular_q_learning_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
